// ----- hw/rtl/fcsr_pkg.sv -----
// Package for the filled circle span rasterizer: screen and radius limits,
// field widths, sequencer states and the square-root unit status struct.
// No dependencies.
package fcsr_pkg;

   localparam int SCREEN_COLS = 1024;
   localparam int SCREEN_ROWS = 1024;
   localparam int MAX_RADIUS  = 31;

   localparam int COORD_W = 12;            // centre coordinate width
   localparam int EXT_W   = COORD_W + 1;   // room for centre +/- radius
   localparam int RAD_W   = 5;             // radius and half-width width
   localparam int SQ_W    = 2 * RAD_W;     // squared radius width
   localparam int REM_W   = RAD_W + 3;     // partial remainder of the root
   localparam int CNT_W   = $clog2(RAD_W + 1);
   localparam int COL_W   = 10;            // span column and row field width
   localparam int COLOR_W = 8;
   localparam int WORD_W  = 32;

   localparam logic signed [EXT_W-1:0] COL_MAX = EXT_W'(SCREEN_COLS - 1);
   localparam logic signed [EXT_W-1:0] ROW_MAX = EXT_W'(SCREEN_ROWS - 1);
   localparam logic [COLOR_W-1:0]      ALPHA   = 8'hFF;

   typedef enum logic [2:0] {
      S_IDLE,
      S_START,
      S_ROOT,
      S_LOWER,
      S_UPPER
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } root_sts_type;

endpackage

// ----- hw/rtl/fcsr_root_unit.sv -----
// Iterative integer square root: two radicand bits per cycle, one
// compare-and-subtract step, floor result. Depends on fcsr_pkg.
module fcsr_root_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fcsr_pkg::SQ_W-1:0]   value,
   output fcsr_pkg::root_sts_type      sts,
   output logic [fcsr_pkg::RAD_W-1:0]  root
);
   import fcsr_pkg::*;

   logic [SQ_W-1:0]  val_ff, val_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [RAD_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic             fits;

   // one restoring step: bring down two bits, try (root*4 + 1)
   assign rem_sh = {rem_ff[REM_W-3:0], val_ff[SQ_W-1 -: 2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign fits   = (rem_sh >= trial);

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(RAD_W);
      end else if (cnt_ff != '0) begin
         val_in  = {val_ff[SQ_W-3:0], 2'b00};
         rem_in  = fits ? (rem_sh - trial) : rem_sh;
         root_in = {root_ff[RAD_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
   assign root     = root_ff;

endmodule

// ----- hw/rtl/filled_circle_span_rasterizer.sv -----
// Top level of the filled circle span rasterizer: sequencer, span clipping
// and output register. Depends on fcsr_pkg and fcsr_root_unit.
//
// One req transaction carries a circle (centre, radius, colour). For each row
// offset y = 0..radius the block computes the half-width floor(sqrt(r*r-y*y))
// in a shared iterative square-root unit (one radicand bit pair per cycle,
// five steps), then sends two rsp transactions: the lower row (cy + y) first,
// then the upper row (cy - y); the centre row goes out twice. Spans are
// clipped to the 1024 x 1024 screen; a span off screen carries a cleared
// write flag (rsp_tuser) and zero row and columns. rsp_tlast marks the upper
// span of the last row offset. Radii above 31 saturate to 31. Each row
// offset passes the states S_START, S_ROOT, S_LOWER and S_UPPER; S_ROOT
// waits for the five-step square-root loop, S_LOWER and S_UPPER for a free
// output register. req_tready is high only between circles. The final span
// waits in the output register while the next circle is already accepted.
module filled_circle_span_rasterizer (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [11:0] center_x, [23:12] center_y, [28:24] radius, [36:29] red,
   // [44:37] green, [52:45] blue, [55:53] zero
   input  logic [55:0] req_tdata,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [9:0] span_row, [19:10] span_start, [29:20] span_end,
   // [61:30] pixel_word, [63:62] zero
   output logic [63:0] rsp_tdata,
   // [0] write_enable
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tlast    // last_span
);
   import fcsr_pkg::*;

   state_type state_ff, state_in;

   // circle held for the whole transaction
   logic signed [COORD_W-1:0] cx_ff, cx_in;
   logic signed [COORD_W-1:0] cy_ff, cy_in;
   logic [RAD_W-1:0]          rad_ff, rad_in;
   logic [SQ_W-1:0]           rr_ff, rr_in;
   logic [WORD_W-1:0]         word_ff, word_in;
   logic [RAD_W-1:0]          y_ff, y_in;
   logic [SQ_W-1:0]           y2_ff, y2_in;

   // output register
   logic                      out_valid_ff, out_valid_in;
   logic [COL_W-1:0]          out_row_ff, out_row_in;
   logic [COL_W-1:0]          out_start_ff, out_start_in;
   logic [COL_W-1:0]          out_end_ff, out_end_in;
   logic [WORD_W-1:0]         out_word_ff, out_word_in;
   logic                      out_we_ff, out_we_in;
   logic                      out_last_ff, out_last_in;

   logic                      accept;
   logic                      root_start;
   logic                      load_lower;
   logic                      load_upper;
   logic                      out_free;
   logic                      last_row;
   logic [RAD_W-1:0]          rad_sat;

   root_sts_type              root_sts;
   logic [RAD_W-1:0]          half;

   logic signed [EXT_W-1:0]   sx, ex, row;
   logic signed [EXT_W-1:0]   sx_clip, ex_clip;
   logic                      cols_ok, span_we;

   fcsr_root_unit u_root (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value (rr_ff - y2_ff),
      .sts   (root_sts),
      .root  (half)
   );

   assign out_free = !out_valid_ff || rsp_tready;
   assign last_row = (y_ff == rad_ff);
   assign accept   = req_tvalid && req_tready;
   assign rad_sat  = (req_tdata[28:24] > RAD_W'(MAX_RADIUS)) ?
                     RAD_W'(MAX_RADIUS) : req_tdata[28:24];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_START;
         S_START: state_in = S_ROOT;
         S_ROOT:  if (root_sts.done) state_in = S_LOWER;
         S_LOWER: if (out_free) state_in = S_UPPER;
         S_UPPER: if (out_free) state_in = last_row ? S_IDLE : S_START;
         default: state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      root_start = 1'b0;
      load_lower = 1'b0;
      load_upper = 1'b0;
      case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_START: root_start = 1'b1;
         S_LOWER: load_lower = out_free;
         S_UPPER: load_upper = out_free;
         default: ;
      endcase
   end

   // span geometry from the half-width just found
   always_comb begin
      sx  = EXT_W'(cx_ff) - $signed({1'b0, half});
      ex  = EXT_W'(cx_ff) + $signed({1'b0, half});
      row = (state_ff == S_UPPER) ? EXT_W'(cy_ff) - $signed({1'b0, y_ff})
                                  : EXT_W'(cy_ff) + $signed({1'b0, y_ff});
      cols_ok = !(sx > COL_MAX || ex < 0);
      sx_clip = (sx < 0) ? '0 : sx;
      ex_clip = (ex > COL_MAX) ? COL_MAX : ex;
      span_we = cols_ok && row >= 0 && row <= ROW_MAX;
   end

   // circle registers and row-offset walk; (y+1)^2 = y^2 + 2y + 1
   always_comb begin
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      rad_in  = rad_ff;
      rr_in   = rr_ff;
      word_in = word_ff;
      y_in    = y_ff;
      y2_in   = y2_ff;
      if (accept) begin
         cx_in   = req_tdata[11:0];
         cy_in   = req_tdata[23:12];
         rad_in  = rad_sat;
         rr_in   = rad_sat * rad_sat;
         word_in = {req_tdata[36:29], req_tdata[44:37], req_tdata[52:45], ALPHA};
         y_in    = '0;
         y2_in   = '0;
      end else if (load_upper && !last_row) begin
         y_in  = y_ff + RAD_W'(1);
         y2_in = y2_ff + {{(SQ_W-RAD_W-1){1'b0}}, y_ff, 1'b1};
      end
   end

   // output register: load a span when free, drop valid once taken
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_row_in   = out_row_ff;
      out_start_in = out_start_ff;
      out_end_in   = out_end_ff;
      out_word_in  = out_word_ff;
      out_we_in    = out_we_ff;
      out_last_in  = out_last_ff;
      if (load_lower || load_upper) begin
         out_valid_in = 1'b1;
         out_row_in   = span_we ? row[COL_W-1:0] : '0;
         out_start_in = span_we ? sx_clip[COL_W-1:0] : '0;
         out_end_in   = span_we ? ex_clip[COL_W-1:0] : '0;
         out_word_in  = word_ff;
         out_we_in    = span_we;
         out_last_in  = load_upper && last_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      rad_ff       <= rad_in;
      rr_ff        <= rr_in;
      word_ff      <= word_in;
      y_ff         <= y_in;
      y2_ff        <= y2_in;
      out_row_ff   <= out_row_in;
      out_start_ff <= out_start_in;
      out_end_ff   <= out_end_in;
      out_word_ff  <= out_word_in;
      out_we_ff    <= out_we_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {2'b00, out_word_ff, out_end_ff, out_start_ff, out_row_ff};
   assign rsp_tuser[0] = out_we_ff;
   assign rsp_tlast    = out_last_ff;

   // an accepted circle always starts a root computation next
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_START)
      else $error("accepted circle did not start the square-root unit");

   // the root unit reports done only at the end of a busy run
   a_root_done: assert property (@(posedge clock) disable iff (reset)
      root_sts.done |-> $past(root_sts.busy))
      else $error("square-root done without a preceding run");

   // a span without write flag carries zero row and columns
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> rsp_tdata[29:0] == 30'd0)
      else $error("hidden span carries nonzero geometry");

   // a written span never runs backward
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> rsp_tdata[19:10] <= rsp_tdata[29:20])
      else $error("span start beyond span end");

endmodule

// ----- tb/tb_filled_circle_span_rasterizer.sv -----
// Testbench for filled_circle_span_rasterizer: directed and random circles,
// predicted spans checked field by field by a small scoreboard class.
// Depends on fcsr_pkg and the block's RTL only.
module tb_filled_circle_span_rasterizer;
   import fcsr_pkg::*;

   // One circle as it travels in req_tdata, first field in the lowest bits.
   typedef struct packed {
      logic [COLOR_W-1:0]        blue;
      logic [COLOR_W-1:0]        green;
      logic [COLOR_W-1:0]        red;
      logic [RAD_W-1:0]          radius;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_x;
   } circle_t;

   // One span as seen on the rsp channel.
   typedef struct {
      logic [COL_W-1:0]  row;
      logic [COL_W-1:0]  first_col;
      logic [COL_W-1:0]  last_col;
      logic [WORD_W-1:0] pixel_word;
      logic              write_enable;
      logic              last_span;
   } span_t;

   // Scoreboard: turns each accepted circle into its expected spans and
   // compares every accepted span with the oldest one still waiting.
   class span_scoreboard;
      span_t pending_spans[$];
      int    fail_count;
      int    circles_seen;
      int    spans_checked;
      int    visible_spans;

      function int root_floor(int v);
         int r;
         r = 0;
         while ((r + 1) * (r + 1) <= v) r++;
         return r;
      endfunction

      function void note_circle(circle_t c);
         int          cx, cy, rad, h, sx, ex, row;
         bit          cols_ok;
         logic [31:0] word;
         span_t       s;
         cx   = $signed(c.center_x);
         cy   = $signed(c.center_y);
         rad  = c.radius;
         if (rad > MAX_RADIUS) rad = MAX_RADIUS;
         word = {c.red, c.green, c.blue, ALPHA};
         circles_seen++;
         for (int y = 0; y <= rad; y++) begin
            h       = root_floor(rad * rad - y * y);
            sx      = cx - h;
            ex      = cx + h;
            cols_ok = !(sx > SCREEN_COLS - 1 || ex < 0);
            if (sx < 0) sx = 0;
            if (ex > SCREEN_COLS - 1) ex = SCREEN_COLS - 1;
            for (int side = 0; side < 2; side++) begin
               row = (side == 0) ? cy + y : cy - y;
               s.write_enable = cols_ok && row >= 0 && row <= SCREEN_ROWS - 1;
               s.row          = s.write_enable ? COL_W'(row) : '0;
               s.first_col    = s.write_enable ? COL_W'(sx) : '0;
               s.last_col     = s.write_enable ? COL_W'(ex) : '0;
               s.pixel_word   = word;
               s.last_span    = (side == 1 && y == rad);
               pending_spans.push_back(s);
            end
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
         if (exp_v !== got_v) begin
            $display("%0t: mismatch on %s, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_v, got_v);
            fail_count++;
         end
      endfunction

      function void check_span(span_t got);
         span_t exp_s;
         if (pending_spans.size() == 0) begin
            $display("%0t: span with none expected, actual row %0d cols %0d..%0d",
                     $time, got.row, got.first_col, got.last_col);
            fail_count++;
            return;
         end
         exp_s = pending_spans.pop_front();
         spans_checked++;
         if (exp_s.write_enable) visible_spans++;
         compare_field("span_row", exp_s.row, got.row);
         compare_field("span_start", exp_s.first_col, got.first_col);
         compare_field("span_end", exp_s.last_col, got.last_col);
         compare_field("pixel_word", exp_s.pixel_word, got.pixel_word);
         compare_field("write_enable", exp_s.write_enable, got.write_enable);
         compare_field("last_span", exp_s.last_span, got.last_span);
      endfunction

      function int pending();
         return pending_spans.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tlast;

   span_scoreboard sb;
   bit             steady;   // set: neither side idles
   span_t          got_span;

   filled_circle_span_rasterizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock, period 10.
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Idle length for either side: mostly none or short, now and then long.
   function int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function circle_t make_circle(int cx, int cy, int rad, int r, int g, int b);
      circle_t c;
      c.center_x = COORD_W'(cx);
      c.center_y = COORD_W'(cy);
      c.radius   = RAD_W'(rad);
      c.red      = COLOR_W'(r);
      c.green    = COLOR_W'(g);
      c.blue     = COLOR_W'(b);
      return c;
   endfunction

   // Random circle: most near the screen so spans clip at the edges, the
   // rest anywhere in the coordinate range. Radii lean to the extremes.
   function circle_t random_circle();
      circle_t c;
      int      roll;
      if ($urandom_range(0, 9) < 7) begin
         c.center_x = COORD_W'(int'($urandom_range(0, 1103)) - 40);
         c.center_y = COORD_W'(int'($urandom_range(0, 1103)) - 40);
      end else begin
         c.center_x = COORD_W'($urandom);
         c.center_y = COORD_W'($urandom);
      end
      roll = $urandom_range(0, 99);
      if (roll < 60)      c.radius = RAD_W'($urandom_range(0, MAX_RADIUS));
      else if (roll < 85) c.radius = RAD_W'($urandom_range(0, 4));
      else                c.radius = RAD_W'($urandom_range(MAX_RADIUS - 3, MAX_RADIUS));
      c.red   = COLOR_W'($urandom);
      c.green = COLOR_W'($urandom);
      c.blue  = COLOR_W'($urandom);
      return c;
   endfunction

   // Offer one circle after a random gap and hold it until the block takes
   // the transaction. Each falling edge carries at most one update of
   // req_tvalid, so back-to-back circles keep it high.
   task send_circle(input circle_t c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, c};
      do @(posedge clock); while (!req_tready);
      sb.note_circle(c);
   endtask

   task send_random(input int count);
      for (int i = 0; i < count; i++) send_circle(random_circle());
   endtask

   // Response side: drop rsp_tready for random stretches at falling edges.
   initial begin
      int stall_left;
      rsp_tready = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Sample every span transaction at the rising edge and score it.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got_span.row          = rsp_tdata[9:0];
            got_span.first_col    = rsp_tdata[19:10];
            got_span.last_col     = rsp_tdata[29:20];
            got_span.pixel_word   = rsp_tdata[61:30];
            got_span.write_enable = rsp_tuser[0];
            got_span.last_span    = rsp_tlast;
            sb.check_span(got_span);
         end
      end
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #40_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      sb         = new();
      steady     = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed circles: smallest and largest radius, screen corners,
      // centres at the coordinate extremes, spans clipped on each side,
      // spans wholly off screen, rows off the top and the bottom, and
      // colour words with all bits low, all high and alternating.
      send_circle(make_circle(0, 0, 0, 8'h00, 8'h00, 8'h00));
      send_circle(make_circle(512, 512, MAX_RADIUS, 8'hFF, 8'hFF, 8'hFF));
      send_circle(make_circle(SCREEN_COLS - 1, SCREEN_ROWS - 1, 0, 8'hAA, 8'h55, 8'hAA));
      send_circle(make_circle(300, 400, 1, 8'h55, 8'hAA, 8'h55));
      send_circle(make_circle(-5, 100, 10, 8'h12, 8'h34, 8'h56));
      send_circle(make_circle(-40, 100, MAX_RADIUS, 8'h80, 8'h01, 8'h7F));
      send_circle(make_circle(-9, 200, 9, 8'hC3, 8'h3C, 8'h99));
      send_circle(make_circle(1030, 600, 12, 8'h01, 8'h02, 8'h04));
      send_circle(make_circle(1060, 500, MAX_RADIUS, 8'hF0, 8'h0F, 8'hE1));
      send_circle(make_circle(1032, 500, 9, 8'h66, 8'h77, 8'h88));
      send_circle(make_circle(500, -10, 8, 8'h10, 8'h20, 8'h30));
      send_circle(make_circle(500, 1030, 10, 8'hFE, 8'hDC, 8'hBA));
      send_circle(make_circle(300, 5, 20, 8'h0A, 8'hB0, 8'h0C));
      send_circle(make_circle(700, SCREEN_ROWS - 3, 20, 8'hDE, 8'hAD, 8'hBE));
      send_circle(make_circle(-2048, -2048, MAX_RADIUS, 8'hFF, 8'h00, 8'hFF));
      send_circle(make_circle(2047, 2047, MAX_RADIUS, 8'h00, 8'hFF, 8'h00));
      send_circle(make_circle(-2048, 2047, 5, 8'h5A, 8'hA5, 8'h3C));
      send_circle(make_circle(2047, -2048, 5, 8'hA5, 8'h5A, 8'hC3));
      send_circle(make_circle(0, 512, MAX_RADIUS, 8'h11, 8'h22, 8'h33));
      send_circle(make_circle(SCREEN_COLS - 1, 512, MAX_RADIUS, 8'h44, 8'h55, 8'h66));
      send_circle(make_circle(512, 0, MAX_RADIUS, 8'h77, 8'h88, 8'h99));

      // Random circles in phases: idling, then a stretch with none, then
      // idling again.
      send_random(70);
      steady = 1'b1;
      send_random(40);
      steady = 1'b0;
      send_random(60);

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Drain every expected span, then watch a while for strays.
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d circles and %0d spans, %0d of them visible",
               sb.circles_seen, sb.spans_checked, sb.visible_spans);
      if (sb.fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
